// ===== src/c8c_pkg.sv =====
// Shared constants, opcode codes and the helper function of the CHIP-8 instruction core.
package c8c_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int ADDR_W         = 12;
  localparam int STACK_DEPTH    = 16;
  localparam int SP_W           = 5;
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;
  localparam int ROW_W          = 5;
  localparam int NUM_REGS       = 16;

  localparam logic [ADDR_W-1:0] PROGRAM_START_RESET = 12'd512;

  // Item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  // Top nibble of the opcode
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEI   = 4'h3;
  localparam logic [3:0] OP_SNEI  = 4'h4;
  localparam logic [3:0] OP_SER   = 4'h5;
  localparam logic [3:0] OP_LDI   = 4'h6;
  localparam logic [3:0] OP_ADDI  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNER  = 4'h9;
  localparam logic [3:0] OP_LDIDX = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRAW  = 4'hD;
  localparam logic [3:0] OP_MISC  = 4'hF;

  // Low byte of 0nnn
  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  // Low nibble of 8xyN
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Low byte of Fxkk
  localparam logic [7:0] FX_DT_RD  = 8'h07;
  localparam logic [7:0] FX_KEY    = 8'h0A;
  localparam logic [7:0] FX_DT_WR  = 8'h15;
  localparam logic [7:0] FX_ST_WR  = 8'h18;
  localparam logic [7:0] FX_IDX    = 8'h1E;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_STORE  = 8'h55;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  localparam logic [3:0] REG_FLAG = 4'hF;

  // Decimal digit of an 8-bit value: position 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [7:0]  hund;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [7:0]  tens;
    logic [7:0]  ones;
    hund = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
    rem  = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
    prod = {8'b0, rem} * 16'd205;
    tens = {3'b0, prod[15:11]};
    ones = rem - tens * 8'd10;
    case (pos)
      2'd0:    bcd_digit = hund;
      2'd1:    bcd_digit = tens;
      default: bcd_digit = ones;
    endcase
  endfunction

endpackage

// ===== src/c8c_cmd_if.sv =====
// Command channel: one item (load, execute or row read) per handshake.
interface c8c_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [c8c_pkg::ADDR_W-1:0] address;
  logic [7:0]                 data;
  logic [7:0]                 random_byte;

  modport source(output valid, kind, address, data, random_byte, input ready);
  modport sink(input valid, kind, address, data, random_byte, output ready);
endinterface

// ===== src/c8c_rsp_if.sv =====
// Response channel: one status word per command item.
interface c8c_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [c8c_pkg::ADDR_W-1:0]        program_counter;
  logic [c8c_pkg::DISPLAY_WIDTH-1:0] row_pixels;
  logic                              display_changed;
  logic                              sound_on;
  logic                              fault;

  modport source(output valid, program_counter, row_pixels, display_changed, sound_on, fault,
                 input ready);
  modport sink(input valid, program_counter, row_pixels, display_changed, sound_on, fault,
               output ready);
endinterface

// ===== src/c8c_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module c8c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/chip8_instruction_core_top.sv =====
// CHIP-8 instruction core: sequencer around main memory, register file, stack and frame RAMs.
//
// Usage: items enter on cmd (valid/ready) and each gives exactly one status word on rsp.
//   kind 0 writes one byte of main memory, kind 1 executes one instruction at the program
//   counter, kind 2 returns one 64-pixel display row (bit 63 leftmost). The configuration
//   port (cfg_we, cfg_data) loads the program counter; write it only while the core is idle.
// Steps: an instruction fetches both opcode bytes, reads Vx and Vy, decodes, executes and
//   updates the timers. A sprite draw repeats its read and write steps for each sprite line,
//   Fx55 and Fx65 repeat them for each register moved, and BCD writes its three digits in
//   turn. Every fetch, register read and frame row read is one access to the single read
//   port of its RAM, with registered read data. One item is in work at a time.
// Reset: rst (synchronous, active high) clears registers, timers, stack pointer, fault and
//   the display (per-row valid bits), and loads the program counter with 512. Main memory
//   and the return stack hold whatever they hold until written.
// Stall: a finished word waits in the output register while rsp.ready is low; the next
//   item is still taken and worked, and its word waits until the output register frees.
// Fault: a call on a full stack or a return on an empty one sets a sticky fault; further
//   execute items then change nothing until reset.
module chip8_instruction_core_top (
  input  logic                       clk,
  input  logic                       rst,
  c8c_cmd_if.sink                    cmd,
  c8c_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [c8c_pkg::ADDR_W-1:0] cfg_data
);
  import c8c_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ROW      = 5'd1;
  localparam logic [4:0] S_FETCH1   = 5'd2;
  localparam logic [4:0] S_FETCH2   = 5'd3;
  localparam logic [4:0] S_RDX      = 5'd4;
  localparam logic [4:0] S_RDY      = 5'd5;
  localparam logic [4:0] S_DEC      = 5'd6;
  localparam logic [4:0] S_EXEC     = 5'd7;
  localparam logic [4:0] S_ALUWR    = 5'd8;
  localparam logic [4:0] S_RET      = 5'd9;
  localparam logic [4:0] S_DRAW_RD  = 5'd10;
  localparam logic [4:0] S_DRAW_WR  = 5'd11;
  localparam logic [4:0] S_DRAW_END = 5'd12;
  localparam logic [4:0] S_BCD      = 5'd13;
  localparam logic [4:0] S_BLK_RD   = 5'd14;
  localparam logic [4:0] S_BLK_WR   = 5'd15;
  localparam logic [4:0] S_TIMERS   = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  localparam int RF_AW = $clog2(NUM_REGS);
  localparam int ST_AW = $clog2(STACK_DEPTH);

  logic [4:0]          state;
  logic [4:0]          state_next;
  logic [1:0]          kind;
  logic [ADDR_W-1:0]   addr;
  logic [7:0]          data;
  logic [7:0]          rnd;
  logic [ADDR_W-1:0]   pc;
  logic [ADDR_W-1:0]   npc;
  logic [15:0]         index;
  logic [SP_W-1:0]     sp;
  logic [7:0]          dt;
  logic [7:0]          st;
  logic                fault;
  logic [7:0]          op_hi;
  logic [15:0]         op;
  logic [7:0]          vx;
  logic [7:0]          vy;
  logic [7:0]          alu_res;
  logic [3:0]          cnt;
  logic                coll;
  logic                changed;
  logic [DISPLAY_WIDTH-1:0] row;

  logic [NUM_REGS-1:0]       rf_valid;
  logic [DISPLAY_HEIGHT-1:0] fr_valid;
  logic [RF_AW-1:0]          rf_raddr_q;
  logic [ROW_W-1:0]          fr_raddr_q;

  // RAM ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_q;
  logic              rf_we;
  logic [RF_AW-1:0]  rf_waddr;
  logic [7:0]        rf_wdata;
  logic [RF_AW-1:0]  rf_raddr;
  logic [7:0]        rf_q;
  logic [7:0]        rf_rd;
  logic              fr_we;
  logic [ROW_W-1:0]  fr_waddr;
  logic [DISPLAY_WIDTH-1:0] fr_wdata;
  logic [ROW_W-1:0]  fr_raddr;
  logic [DISPLAY_WIDTH-1:0] fr_q;
  logic [DISPLAY_WIDTH-1:0] fr_rd;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_q;
  logic [SP_W-1:0]   sp_m1;

  // Opcode fields
  logic [3:0]        op_top;
  logic [3:0]        op_x;
  logic [3:0]        op_y;
  logic [3:0]        op_n;
  logic [7:0]        op_kk;
  logic [ADDR_W-1:0] op_nnn;
  logic [ADDR_W-1:0] pc_plus2;

  // ALU and draw datapath
  logic              alu_flag;
  logic              alu_flag_op;
  logic [7:0]        ex;
  logic [7:0]        ey;
  logic [8:0]        sum;
  logic [7:0]        res;
  logic [DISPLAY_WIDTH-1:0] spr;
  logic [2*DISPLAY_WIDTH-1:0] spr_rot;
  logic [DISPLAY_WIDTH-1:0] mask;
  logic [ADDR_W-1:0] idx_cnt;

  assign op_top   = op[15:12];
  assign op_x     = op[11:8];
  assign op_y     = op[7:4];
  assign op_n     = op[3:0];
  assign op_kk    = op[7:0];
  assign op_nnn   = op[11:0];
  assign pc_plus2 = pc + 12'd2;
  assign sp_m1    = sp - 5'd1;
  assign idx_cnt  = index[ADDR_W-1:0] + {8'b0, cnt};

  assign rf_rd = rf_valid[rf_raddr_q] ? rf_q : 8'd0;
  assign fr_rd = fr_valid[fr_raddr_q] ? fr_q : '0;

  c8c_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

  c8c_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_q)
  );

  c8c_ram #(.WIDTH(DISPLAY_WIDTH), .DEPTH(DISPLAY_HEIGHT)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_q)
  );

  c8c_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp[ST_AW-1:0]), .wdata(pc_plus2),
    .raddr(sp_m1[ST_AW-1:0]), .rdata(stk_q)
  );

  // ALU: flag first, then result from the updated registers
  always_comb begin
    sum = {1'b0, vx} + {1'b0, vy};
    alu_flag_op = 1'b1;
    case (op_n)
      ALU_ADD: alu_flag = sum[8];
      ALU_SUB: alu_flag = vx > vy;
      ALU_SHR: alu_flag = vx[0];
      ALU_SBN: alu_flag = vy > vx;
      ALU_SHL: alu_flag = vx[7];
      default: begin
        alu_flag    = 1'b0;
        alu_flag_op = 1'b0;
      end
    endcase
    ex = (alu_flag_op && op_x == REG_FLAG) ? {7'b0, alu_flag} : vx;
    ey = (alu_flag_op && op_y == REG_FLAG) ? {7'b0, alu_flag} : vy;
    case (op_n)
      ALU_MOV: res = ey;
      ALU_OR:  res = ex | ey;
      ALU_AND: res = ex & ey;
      ALU_XOR: res = ex ^ ey;
      ALU_ADD: res = ex + ey;
      ALU_SUB: res = ex - ey;
      ALU_SHR: res = {1'b0, ex[7:1]};
      ALU_SBN: res = ey - ex;
      ALU_SHL: res = {ex[6:0], 1'b0};
      default: res = ex;
    endcase
  end

  // Sprite line rotated to its column with wrap
  always_comb begin
    spr     = {mem_q, {(DISPLAY_WIDTH-8){1'b0}}};
    spr_rot = {spr, spr} >> vx[5:0];
    mask    = spr_rot[DISPLAY_WIDTH-1:0];
  end

  // RAM addresses, write strobes and next state
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = addr;
    mem_wdata  = data;
    mem_raddr  = pc;
    rf_we      = 1'b0;
    rf_waddr   = op_x;
    rf_wdata   = 8'd0;
    rf_raddr   = op_x;
    fr_we      = 1'b0;
    fr_waddr   = fr_raddr_q;
    fr_wdata   = fr_rd ^ mask;
    fr_raddr   = addr[ROW_W-1:0];
    stk_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.kind)
            KIND_LOAD: begin
              mem_we     = 1'b1;
              mem_waddr  = cmd.address;
              mem_wdata  = cmd.data;
              state_next = S_DONE;
            end
            KIND_ROW: begin
              fr_raddr   = cmd.address[ROW_W-1:0];
              state_next = S_ROW;
            end
            KIND_EXEC: state_next = fault ? S_DONE : S_FETCH1;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_ROW: state_next = S_DONE;
      S_FETCH1: begin
        mem_raddr  = pc + 12'd1;
        state_next = S_FETCH2;
      end
      S_FETCH2: state_next = S_RDX;
      S_RDX: begin
        rf_raddr   = (op_top == OP_JPV0) ? '0 : op_x;
        state_next = S_RDY;
      end
      S_RDY: begin
        rf_raddr   = op_y;
        state_next = S_DEC;
      end
      S_DEC: state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_TIMERS;
        case (op_top)
          OP_SYS: begin
            if (op_kk == SYS_RET) begin
              state_next = (sp == '0) ? S_DONE : S_RET;
            end
          end
          OP_CALL: begin
            if (sp >= SP_W'(STACK_DEPTH)) begin
              state_next = S_DONE;
            end else begin
              stk_we = 1'b1;
            end
          end
          OP_LDI: begin
            rf_we    = 1'b1;
            rf_wdata = op_kk;
          end
          OP_ADDI: begin
            rf_we    = 1'b1;
            rf_wdata = vx + op_kk;
          end
          OP_ALU: begin
            if (alu_flag_op) begin
              rf_we      = 1'b1;
              rf_waddr   = REG_FLAG;
              rf_wdata   = {7'b0, alu_flag};
              state_next = S_ALUWR;
            end else if (op_n == ALU_MOV || op_n == ALU_OR || op_n == ALU_AND ||
                         op_n == ALU_XOR) begin
              rf_we    = 1'b1;
              rf_wdata = res;
            end
          end
          OP_RND: begin
            rf_we    = 1'b1;
            rf_wdata = rnd & op_kk;
          end
          OP_DRAW: state_next = (op_n == 4'd0) ? S_DRAW_END : S_DRAW_RD;
          OP_MISC: begin
            case (op_kk)
              FX_DT_RD: begin
                rf_we    = 1'b1;
                rf_wdata = dt;
              end
              FX_KEY: begin
                rf_we    = 1'b1;
                rf_wdata = 8'd0;
              end
              FX_BCD:   state_next = S_BCD;
              FX_STORE: state_next = S_BLK_RD;
              FX_LOAD:  state_next = S_BLK_RD;
              default:  state_next = S_TIMERS;
            endcase
          end
          default: state_next = S_TIMERS;
        endcase
      end
      S_ALUWR: begin
        rf_we      = 1'b1;
        rf_wdata   = alu_res;
        state_next = S_TIMERS;
      end
      S_RET: state_next = S_TIMERS;
      S_DRAW_RD: begin
        mem_raddr  = idx_cnt;
        fr_raddr   = vy[ROW_W-1:0] + {1'b0, cnt};
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        fr_we      = 1'b1;
        state_next = (cnt + 4'd1 == op_n) ? S_DRAW_END : S_DRAW_RD;
      end
      S_DRAW_END: begin
        rf_we      = 1'b1;
        rf_waddr   = REG_FLAG;
        rf_wdata   = {7'b0, coll};
        state_next = S_TIMERS;
      end
      S_BCD: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_cnt;
        mem_wdata  = bcd_digit(vx, cnt[1:0]);
        state_next = (cnt == 4'd2) ? S_TIMERS : S_BCD;
      end
      S_BLK_RD: begin
        rf_raddr   = cnt;
        mem_raddr  = idx_cnt;
        state_next = S_BLK_WR;
      end
      S_BLK_WR: begin
        if (op_kk == FX_STORE) begin
          mem_we    = 1'b1;
          mem_waddr = idx_cnt;
          mem_wdata = rf_rd;
        end else begin
          rf_we    = 1'b1;
          rf_waddr = cnt;
          rf_wdata = mem_q;
        end
        state_next = (cnt == op_x) ? S_TIMERS : S_BLK_RD;
      end
      S_TIMERS: state_next = S_DONE;
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PROGRAM_START_RESET;
      index     <= '0;
      sp        <= '0;
      dt        <= '0;
      st        <= '0;
      fault     <= 1'b0;
      rf_valid  <= '0;
      fr_valid  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      if (fr_we) begin
        fr_valid[fr_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        pc <= cfg_data;
      end
      // retire the shown word, then post the new one
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end
      case (state)
        S_EXEC: begin
          case (op_top)
            OP_SYS: begin
              if (op_kk == SYS_CLS) begin
                fr_valid <= '0;
              end else if (op_kk == SYS_RET) begin
                if (sp == '0) begin
                  fault <= 1'b1;
                end else begin
                  sp <= sp_m1;
                end
              end
            end
            OP_CALL: begin
              if (sp >= SP_W'(STACK_DEPTH)) begin
                fault <= 1'b1;
              end else begin
                sp <= sp + 5'd1;
              end
            end
            OP_LDIDX: index <= {4'b0, op_nnn};
            OP_MISC: begin
              case (op_kk)
                FX_DT_WR: dt <= vx;
                FX_ST_WR: st <= vx;
                FX_IDX:   index <= index + {8'b0, vx};
                default:  ;
              endcase
            end
            default: ;
          endcase
        end
        S_DRAW_END: index <= index + {12'b0, op_n};
        S_TIMERS: begin
          pc <= npc;
          if (st != 8'd0) begin
            st <= st - 8'd1;
          end
          if (dt != 8'd0) begin
            dt <= dt - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    rf_raddr_q <= rf_raddr;
    fr_raddr_q <= fr_raddr;
    case (state)
      S_IDLE: begin
        kind    <= cmd.kind;
        addr    <= cmd.address;
        data    <= cmd.data;
        rnd     <= cmd.random_byte;
        row     <= '0;
        changed <= 1'b0;
      end
      S_ROW:    row <= fr_rd;
      S_FETCH1: op_hi <= mem_q;
      S_FETCH2: op <= {op_hi, mem_q};
      S_RDY:    vx <= rf_rd;
      S_DEC:    vy <= rf_rd;
      S_EXEC: begin
        npc     <= pc_plus2;
        alu_res <= res;
        cnt     <= '0;
        coll    <= 1'b0;
        case (op_top)
          OP_SYS:  changed <= (op_kk == SYS_CLS);
          OP_JP:   npc <= op_nnn;
          OP_CALL: npc <= op_nnn;
          OP_SEI:  if (vx == op_kk) npc <= pc + 12'd4;
          OP_SNEI: if (vx != op_kk) npc <= pc + 12'd4;
          OP_SER:  if (vx == vy) npc <= pc + 12'd4;
          OP_SNER: if (vx != vy) npc <= pc + 12'd4;
          OP_JPV0: npc <= op_nnn + {4'b0, vx};
          OP_DRAW: changed <= 1'b1;
          default: ;
        endcase
      end
      S_RET: npc <= stk_q;
      S_DRAW_WR: begin
        coll <= coll | (|(fr_rd & mask));
        cnt  <= cnt + 4'd1;
      end
      S_BCD:    cnt <= cnt + 4'd1;
      S_BLK_WR: cnt <= cnt + 4'd1;
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.program_counter <= pc;
          rsp.row_pixels      <= row;
          rsp.display_changed <= changed;
          rsp.sound_on        <= (st != 8'd0);
          rsp.fault           <= fault;
        end
      end
      default: ;
    endcase
  end

  // Fault is sticky until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst) fault |=> fault)
    else $error("fault cleared without reset");

  // Stack depth never exceeds its capacity
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer out of range");

  // A faulting call or return leaves the program counter alone
  a_fault_pc: assert property (@(posedge clk) disable iff (rst)
    (!fault && state == S_EXEC && (op_top == OP_SYS || op_top == OP_CALL)) ##1 $rose(fault)
      |-> $stable(pc))
    else $error("program counter moved on stack fault");

endmodule

// ===== verif/chip8_instruction_core_top_tb.sv =====
// Self-checking testbench of the CHIP-8 instruction core: random programs against a predictor.
module chip8_instruction_core_top_tb;
  import c8c_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  rnd;
  } item_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [63:0] row;
    logic        chg;
    logic        snd;
    logic        flt;
  } word_t;

  typedef struct packed {
    item_t it;
    word_t w;
  } job_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_data;

  c8c_cmd_if cmd ();
  c8c_rsp_if rsp ();

  chip8_instruction_core_top dut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted core state
  logic [7:0]  img [MEM_BYTES];
  bit          wr [MEM_BYTES];
  logic [7:0]  v [NUM_REGS];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [11:0] stk [STACK_DEPTH];
  logic [4:0]  sp;
  logic [7:0]  dt, st;
  logic [63:0] frame [DISPLAY_HEIGHT];
  logic        flt;

  job_t  send_q [$];
  word_t want_q [$];
  job_t  cur;
  int    gap, stall, hold_left;
  bit    hold_done;
  bit    idle_on = 1'b1;
  int    errors, results_seen, n_items, n_exec, n_draw, n_rows;

  // Advance the predicted state by one item and return the status word it yields
  function automatic word_t core_step(item_t c);
    logic [15:0] op;
    logic [3:0]  top, x, y, n;
    logic [7:0]  kk, px, py, bits, a;
    logic [11:0] nnn, nxt, ia;
    logic [63:0] row;
    logic        chg, halt;
    int          r, col;
    word_t       s;
    chg = 1'b0;
    halt = 1'b0;
    row = '0;
    case (c.kind)
      KIND_LOAD: begin
        img[c.addr] = c.data;
        wr[c.addr] = 1'b1;
      end
      KIND_EXEC: if (!flt) begin
        n_exec++;
        op = {img[pc], img[pc + 12'd1]};
        top = op[15:12]; x = op[11:8]; y = op[7:4]; n = op[3:0];
        kk = op[7:0]; nnn = op[11:0];
        nxt = pc + 12'd2;
        if (top == OP_RND) v[x] = c.rnd & kk;
        case (top)
          OP_SYS: begin
            if (kk == SYS_CLS) begin
              for (int i = 0; i < DISPLAY_HEIGHT; i++) frame[i] = '0;
              chg = 1'b1;
            end else if (kk == SYS_RET) begin
              if (sp == 0) begin
                flt = 1'b1;
                halt = 1'b1;
              end else begin
                sp--;
                nxt = stk[sp[3:0]];
              end
            end
          end
          OP_JP: nxt = nnn;
          OP_CALL: begin
            if (sp >= 5'(STACK_DEPTH)) begin
              flt = 1'b1;
              halt = 1'b1;
            end else begin
              stk[sp[3:0]] = nxt;
              sp++;
              nxt = nnn;
            end
          end
          OP_SEI:  if (v[x] == kk) nxt += 12'd2;
          OP_SNEI: if (v[x] != kk) nxt += 12'd2;
          OP_SER:  if (v[x] == v[y]) nxt += 12'd2;
          OP_SNER: if (v[x] != v[y]) nxt += 12'd2;
          OP_LDI:  v[x] = kk;
          OP_ADDI: v[x] = v[x] + kk;
          OP_LDIDX: idx = {4'd0, nnn};
          OP_JPV0: nxt = nnn + {4'd0, v[0]};
          // Flag goes first, then the result sees the new VF
          OP_ALU: begin
            case (n)
              ALU_MOV: v[x] = v[y];
              ALU_OR:  v[x] = v[x] | v[y];
              ALU_AND: v[x] = v[x] & v[y];
              ALU_XOR: v[x] = v[x] ^ v[y];
              ALU_ADD: begin
                v[REG_FLAG] = ({1'b0, v[x]} + {1'b0, v[y]}) > 9'd255;
                v[x] = v[x] + v[y];
              end
              ALU_SUB: begin
                v[REG_FLAG] = v[x] > v[y];
                v[x] = v[x] - v[y];
              end
              ALU_SHR: begin
                v[REG_FLAG] = {7'd0, v[x][0]};
                v[x] = v[x] >> 1;
              end
              ALU_SBN: begin
                v[REG_FLAG] = v[y] > v[x];
                v[x] = v[y] - v[x];
              end
              ALU_SHL: begin
                v[REG_FLAG] = {7'd0, v[x][7]};
                v[x] = v[x] << 1;
              end
              default: ;
            endcase
          end
          // XOR sprite with wrap on both axes
          OP_DRAW: begin
            px = v[x];
            py = v[y];
            v[REG_FLAG] = 8'd0;
            for (int l = 0; l < n; l++) begin
              ia = idx[11:0] + 12'(l);
              bits = img[ia];
              r = (py + l) % DISPLAY_HEIGHT;
              for (int b = 0; b < 8; b++) begin
                if (bits[7-b]) begin
                  col = (px + b) % DISPLAY_WIDTH;
                  if (frame[r][63-col]) v[REG_FLAG] = 8'd1;
                  frame[r][63-col] = ~frame[r][63-col];
                end
              end
            end
            idx = idx + {12'd0, n};
            chg = 1'b1;
            n_draw++;
          end
          OP_MISC: begin
            case (kk)
              FX_DT_RD: v[x] = dt;
              FX_KEY:   v[x] = 8'd0;
              FX_DT_WR: dt = v[x];
              FX_ST_WR: st = v[x];
              FX_IDX:   idx = idx + {8'd0, v[x]};
              FX_BCD: begin
                a = v[x];
                for (int i = 0; i < 3; i++) begin
                  ia = idx[11:0] + 12'(i);
                  img[ia] = (i == 0) ? a / 100 : ((i == 1) ? (a / 10) % 10 : a % 10);
                  wr[ia] = 1'b1;
                end
              end
              FX_STORE: for (int i = 0; i <= x; i++) begin
                ia = idx[11:0] + 12'(i);
                img[ia] = v[i];
                wr[ia] = 1'b1;
              end
              FX_LOAD: for (int i = 0; i <= x; i++) begin
                ia = idx[11:0] + 12'(i);
                v[i] = img[ia];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        if (!halt) begin
          pc = nxt;
          if (st != 0) st--;
          if (dt != 0) dt--;
        end
      end
      KIND_ROW: begin
        row = frame[c.addr[4:0]];
        n_rows++;
      end
      default: ;
    endcase
    s.pc = pc;
    s.row = row;
    s.chg = chg;
    s.snd = (st != 0);
    s.flt = flt;
    return s;
  endfunction

  function automatic bit stack_safe(logic [15:0] op);
    if (op[15:12] == OP_SYS && op[7:0] == SYS_RET && sp == 0) return 1'b0;
    if (op[15:12] == OP_CALL && sp >= 5'(STACK_DEPTH)) return 1'b0;
    return 1'b1;
  endfunction

  // Pick an opcode, biased toward implemented codes, that keeps the stack in range
  function automatic logic [15:0] pick_op();
    logic [15:0] op;
    logic [3:0]  alu_codes [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                   ALU_SHR, ALU_SBN, ALU_SHL};
    logic [7:0]  fx_codes [8] = '{FX_DT_RD, FX_KEY, FX_DT_WR, FX_ST_WR, FX_IDX, FX_BCD,
                                  FX_STORE, FX_LOAD};
    do begin
      op = 16'($urandom);
      case (op[15:12])
        OP_SYS: case ($urandom_range(0, 3))
          0: op[7:0] = SYS_CLS;
          1, 2: op[7:0] = SYS_RET;
          default: ;
        endcase
        OP_ALU:  if ($urandom_range(0, 7) != 0) op[3:0] = alu_codes[$urandom_range(0, 8)];
        OP_MISC: if ($urandom_range(0, 7) != 0) op[7:0] = fx_codes[$urandom_range(0, 7)];
        OP_SEI, OP_SNEI: if ($urandom_range(0, 1)) op[7:0] = v[op[11:8]];
        OP_SER, OP_SNER: if ($urandom_range(0, 1)) op[7:4] = op[11:8];
        default: ;
      endcase
    end while (!stack_safe(op));
    return op;
  endfunction

  task automatic put(logic [1:0] kind, logic [11:0] addr, logic [7:0] data);
    job_t j;
    j.it.kind = kind;
    j.it.addr = addr;
    j.it.data = data;
    j.it.rnd = 8'($urandom);
    j.w = core_step(j.it);
    send_q.push_back(j);
    n_items++;
  endtask

  // Queue one instruction with the loads it needs: sprite or block bytes, then the opcode
  task automatic put_exec(bit forced, logic [15:0] fop);
    logic [15:0] op;
    logic [11:0] a0, a1, ia;
    bit          fresh;
    int          cnt;
    a0 = pc;
    a1 = pc + 12'd1;
    fresh = 1'b1;
    if (forced) begin
      op = fop;
    end else if (wr[a0] && wr[a1] && $urandom_range(0, 2) == 0) begin
      op = {img[a0], img[a1]};
      fresh = !stack_safe(op);
      if (fresh) op = pick_op();
    end else begin
      op = pick_op();
    end
    cnt = 0;
    if (op[15:12] == OP_DRAW) cnt = op[3:0];
    else if (op[15:12] == OP_MISC && op[7:0] == FX_LOAD) cnt = op[11:8] + 1;
    for (int i = 0; i < cnt; i++) begin
      ia = idx[11:0] + 12'(i);
      if (!wr[ia]) begin
        put(KIND_LOAD, ia, 8'($urandom));
        fresh = 1'b1;
      end
    end
    if (fresh) begin
      put(KIND_LOAD, a0, op[15:8]);
      put(KIND_LOAD, a1, op[7:0]);
    end
    put(KIND_EXEC, 12'($urandom), 8'($urandom));
  endtask

  task automatic random_run(int count);
    int stop;
    stop = n_items + count;
    while (n_items < stop) begin
      case ($urandom_range(0, 19))
        0, 1:    put(KIND_LOAD, 12'($urandom), 8'($urandom));
        2, 3:    put(KIND_ROW, 12'($urandom), 8'($urandom));
        4:       put(2'd3, 12'($urandom), 8'($urandom));
        default: put_exec(1'b0, '0);
      endcase
    end
  endtask

  task automatic wait_idle();
    while (send_q.size() != 0 || cmd.valid || want_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_start(logic [11:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc = val;
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %0s: expected %h got %h (word %0d)", what, exp_v, got_v, results_seen);
  endtask

  // Drive command words; stack the expectation when a word is taken
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      gap <= 0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) want_q.push_back(cur.w);
      if (gap > 0) begin
        gap <= gap - 1;
        cmd.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        gap <= $urandom_range(1, 14);
        cmd.valid <= 1'b0;
      end else if (send_q.size() != 0) begin
        cur = send_q.pop_front();
        cmd.valid <= 1'b1;
        cmd.kind <= cur.it.kind;
        cmd.address <= cur.it.addr;
        cmd.data <= cur.it.data;
        cmd.random_byte <= cur.it.rnd;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Hold off the response side once for a long stretch
  always @(posedge clk) begin
    if (!rst && results_seen >= 200 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check status words against the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (want_q.size() == 0) begin
          report("unexpected word", '0, '0);
        end else begin
          w = want_q.pop_front();
          if (rsp.program_counter !== w.pc) report("program_counter", w.pc, rsp.program_counter);
          if (rsp.row_pixels !== w.row) report("row_pixels", w.row, rsp.row_pixels);
          if (rsp.display_changed !== w.chg)
            report("display_changed", w.chg, rsp.display_changed);
          if (rsp.sound_on !== w.snd) report("sound_on", w.snd, rsp.sound_on);
          if (rsp.fault !== w.flt) report("fault", w.flt, rsp.fault);
        end
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        stall <= $urandom_range(1, 14);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [15:0] dir_ops [10] = '{16'h00E0, 16'h6FFF, 16'h8FF4, 16'h6A3C, 16'hA000,
                                  16'hDAA5, 16'hDAA5, 16'hF033, 16'hCF0F, 16'h5AA0};
    cmd.valid = 1'b0;
    cmd.kind = KIND_LOAD;
    cmd.address = '0;
    cmd.data = '0;
    cmd.random_byte = '0;
    rsp.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    for (int i = 0; i < MEM_BYTES; i++) begin
      img[i] = '0;
      wr[i] = 1'b0;
    end
    for (int i = 0; i < NUM_REGS; i++) v[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
    for (int i = 0; i < DISPLAY_HEIGHT; i++) frame[i] = '0;
    idx = '0; pc = PROGRAM_START_RESET; sp = '0; dt = '0; st = '0; flt = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: clear, flag-order add, draw and collision, BCD, masking, register skip
    for (int i = 0; i < 10; i++) put_exec(1'b1, dir_ops[i]);
    put(KIND_LOAD, 12'hFFF, 8'hFF);
    put(KIND_ROW, 12'hFFF, 8'h00);
    put(KIND_ROW, 12'h000, 8'h00);

    // Random programs from the lowest and highest start and one in between
    set_start(12'h000);
    random_run(300);
    set_start(12'hFFF);
    random_run(300);
    set_start(12'($urandom));
    random_run(260);

    // Last part without idling: fill the stack, overflow it, then run halted
    wait_idle();
    idle_on = 1'b0;
    set_start(PROGRAM_START_RESET);
    while (!flt) put_exec(1'b1, {OP_CALL, 12'($urandom)});
    random_run(40);
    wait_idle();

    $display("ran %0d items: %0d instructions, %0d sprite draws, %0d row reads",
             n_items, n_exec, n_draw, n_rows);
    $display("checked %0d status words across four start addresses, %0d mismatches",
             results_seen, errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
